>>> src/kdpc_pkg.sv
package kdpc_pkg;

	localparam int TIME_BITS = 16;
	localparam int TICK_MS = 10;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_SHORT = 2'd1,
		PH_LONG  = 2'd2,
		PH_ULTRA = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_SHORT   = 3'd1,
		EV_CLICK   = 3'd2,
		EV_LONG    = 3'd3,
		EV_ULTRA   = 3'd4,
		EV_RELEASE = 3'd5
	} ev_code_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_DEBOUNCE_TICKS = 3'd0,
		CFG_SHORT_LIMIT    = 3'd1,
		CFG_LONG_LIMIT     = 3'd2,
		CFG_ULTRA_LIMIT    = 3'd3,
		CFG_ACTIVE_HIGH    = 3'd4,
		CFG_EVENT_ENABLE   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		ev_code_t code;
		logic     last;
	} evt_entry_t;

endpackage

>>> src/kdpc_if.sv
interface kdpc_key_if;
	logic valid;
	logic ready;
	logic raw_level;

	modport source (output valid, output raw_level, input ready);
	modport sink (input valid, input raw_level, output ready);
endinterface

interface kdpc_evt_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_code;
	logic       last_event;

	modport source (output valid, output event_code, output last_event, input ready);
	modport sink (input valid, input event_code, input last_event, output ready);
endinterface

interface kdpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/key_debounce_press_classifier_unit.sv
// Events of an accepted tick are written into the event queue and offered on evt from its head.
// Throughput: one tick per cycle while key.ready is high; the event queue drains one event
// per cycle while evt.ready is high, a tick with two events fills two entries, and key.ready
// drops when the four-entry queue cannot take two more events.
// Reset (arst_n low, asynchronous): all registers but the queue storage return to defaults, the
// key is taken as released, the press phase is idle and the event queue is empty.
module key_debounce_press_classifier_unit (
	input  logic       clk,
	input  logic       arst_n,
	kdpc_key_if.sink   key,
	kdpc_evt_if.source evt,
	kdpc_cfg_if.sink   cfg
);
	import kdpc_pkg::*;

	// Configuration registers.
	logic [7:0]  debounce_ticks_q;
	logic [15:0] short_limit_q;
	logic [15:0] long_limit_q;
	logic [15:0] ultra_limit_q;
	logic        active_high_q;
	logic [5:0]  event_enable_q;

	// Tick state.
	logic        stable_q;
	logic [7:0]  bounce_q;
	time_t       held_q;
	phase_t      phase_q;

	// Event queue.
	evt_entry_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0]   head_q;
	logic [FIFO_PTR_BITS-1:0]   tail_q;
	logic [FIFO_CNT_BITS-1:0]   count_q;

	logic        accept;
	logic        pop;
	logic        cfg_wr;

	logic        stable_d;
	logic [7:0]  bounce_d;
	logic [7:0]  bounce_inc;
	logic        active;
	logic [TIME_BITS:0] held_sum;
	time_t       held_adv;
	time_t       held_d;
	phase_t      phase_d;

	ev_code_t    cand_a_code;
	logic        cand_a_on;
	logic        cand_b_on;
	evt_entry_t  ent0;
	evt_entry_t  ent1;
	logic [1:0]  push_n;

	assign accept = key.valid && key.ready;
	assign pop    = evt.valid && evt.ready;
	assign cfg_wr = cfg.valid && cfg.ready;

	assign key.ready = (count_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
	assign cfg.ready = 1'b1;

	assign evt.valid      = (count_q != '0);
	assign evt.event_code = fifo_q[head_q].code;
	assign evt.last_event = fifo_q[head_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= 8'd2;
			short_limit_q    <= 16'd50;
			long_limit_q     <= 16'd1000;
			ultra_limit_q    <= 16'd3000;
			active_high_q    <= 1'b0;
			event_enable_q   <= 6'h3F;
		end else if (cfg_wr) begin
			case (cfg.index)
				CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg.data[7:0];
				CFG_SHORT_LIMIT:    short_limit_q    <= cfg.data;
				CFG_LONG_LIMIT:     long_limit_q     <= cfg.data;
				CFG_ULTRA_LIMIT:    ultra_limit_q    <= cfg.data;
				CFG_ACTIVE_HIGH:    active_high_q    <= cfg.data[0];
				CFG_EVENT_ENABLE:   event_enable_q   <= cfg.data[5:0];
				default: ;
			endcase
		end
	end

	// Debounce: the new level is what the phase machine sees in the same tick.
	always_comb begin
		bounce_inc = (bounce_q == 8'hFF) ? bounce_q : bounce_q + 8'd1;
		stable_d   = stable_q;
		bounce_d   = 8'd0;
		if (key.raw_level != stable_q) begin
			if (bounce_inc >= debounce_ticks_q) begin
				stable_d = key.raw_level;
			end else begin
				bounce_d = bounce_inc;
			end
		end
		active = (stable_d == active_high_q);
	end

	always_comb begin
		held_sum = {1'b0, held_q} + (TIME_BITS + 1)'(TICK_MS);
		held_adv = held_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : held_sum[TIME_BITS-1:0];
	end

	always_comb begin
		phase_d     = phase_q;
		held_d      = held_q;
		cand_a_code = EV_PRESS;
		cand_a_on   = 1'b0;
		cand_b_on   = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (active) begin
					held_d    = '0;
					phase_d   = PH_SHORT;
					cand_a_on = 1'b1;
				end
			end
			PH_SHORT: begin
				held_d = held_adv;
				if (!active) begin
					phase_d     = PH_IDLE;
					cand_a_code = (32'(held_adv) < 32'(short_limit_q)) ? EV_SHORT : EV_CLICK;
					cand_a_on   = 1'b1;
					cand_b_on   = 1'b1;
				end else if (32'(held_adv) >= 32'(ultra_limit_q)) begin
					phase_d     = PH_ULTRA;
					cand_a_code = EV_ULTRA;
					cand_a_on   = 1'b1;
				end else if (32'(held_adv) >= 32'(long_limit_q)) begin
					phase_d     = PH_LONG;
					cand_a_code = EV_LONG;
					cand_a_on   = 1'b1;
				end
			end
			PH_LONG: begin
				held_d = held_adv;
				if (!active) begin
					phase_d     = PH_IDLE;
					cand_a_code = EV_RELEASE;
					cand_a_on   = 1'b1;
				end else if (32'(held_adv) >= 32'(ultra_limit_q)) begin
					phase_d     = PH_ULTRA;
					cand_a_code = EV_ULTRA;
					cand_a_on   = 1'b1;
				end
			end
			PH_ULTRA: begin
				if (!active) begin
					phase_d     = PH_IDLE;
					cand_a_code = EV_RELEASE;
					cand_a_on   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Masking drops an event, and the last surviving one of the tick is flagged.
	always_comb begin
		logic a_en;
		logic b_en;
		a_en   = cand_a_on && event_enable_q[cand_a_code];
		b_en   = cand_b_on && event_enable_q[EV_RELEASE];
		ent0   = '{code: cand_a_code, last: 1'b1};
		ent1   = '{code: EV_RELEASE, last: 1'b1};
		push_n = 2'd0;
		if (a_en && b_en) begin
			ent0.last = 1'b0;
			push_n    = 2'd2;
		end else if (a_en) begin
			push_n = 2'd1;
		end else if (b_en) begin
			ent0   = '{code: EV_RELEASE, last: 1'b1};
			push_n = 2'd1;
		end
		if (!accept) begin
			push_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b1;
			bounce_q <= 8'd0;
			held_q   <= '0;
			phase_q  <= PH_IDLE;
		end else if (accept) begin
			stable_q <= stable_d;
			bounce_q <= bounce_d;
			held_q   <= held_d;
			phase_q  <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[tail_q] <= ent0;
		end
		if (push_n == 2'd2) begin
			fifo_q[tail_q + FIFO_PTR_BITS'(1)] <= ent1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + FIFO_PTR_BITS'(push_n);
			head_q  <= head_q + FIFO_PTR_BITS'(pop);
			count_q <= count_q + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(pop);
		end
	end

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("event queue overflow");

	a_bounce_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		bounce_q != 8'hFF)
		else $error("debounce counter held at saturation");

	a_ultra_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_ULTRA |=> held_q == $past(held_q))
		else $error("press timer moved in ultra-long phase");

	a_idle_no_timer: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_IDLE && phase_d == PH_SHORT |=> held_q == '0)
		else $error("press timer not cleared on press");
`endif

endmodule
